@@ rtl/core/zsn_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsn_pkg
// Shared widths, defaults and controller/datapath command types.
// ----------------------------------------------------------------------------
package zsn_pkg;

  localparam int MAX_SAMPLES_DEF = 64;

  localparam int SAMPLE_W   = 16;
  localparam int SUM_W      = 22;
  localparam int SQ_W       = 38;
  localparam int PROD_W     = 45;
  localparam int ND_W       = 52;
  localparam int A_W        = 24;
  localparam int MAG_W      = 23;
  localparam int A2_W       = 46;
  localparam int NUM_W      = 53;
  localparam int Q_W        = 32;
  localparam int ROOT_W     = 16;
  localparam int RT_W       = 19;
  localparam int M_W        = 17;
  localparam int FRAC_SHIFT = 26;
  localparam int STEP_W     = 5;

  localparam logic [M_W-1:0]      M_SAT = 17'h10000;
  localparam logic [SAMPLE_W-1:0] Z_MAX = 16'h7fff;

  typedef struct packed {
    logic acc_en;
    logic clear;
    logic prep_mul;
    logic prep_sub;
    logic prep_nd;
    logic rd_en;
    logic a_en;
    logic sq_en;
    logic num_en;
    logic div_init;
    logic div_step;
    logic sqrt_step;
    logic out_load;
  } zsn_cmd_t;

  typedef struct packed {
    logic degen;
    logic sat;
    logic last_item;
    logic out_busy;
  } zsn_status_t;

endpackage

@@ rtl/core/zsn_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsn_in_if
// Sample channel: valid/ready handshake with sample and final marker.
// ----------------------------------------------------------------------------
interface zsn_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [zsn_pkg::SAMPLE_W-1:0] sample;
  logic                                is_final;

  modport source (output valid, output sample, output is_final, input ready);
  modport sink   (input valid, input sample, input is_final, output ready);
endinterface

@@ rtl/core/zsn_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsn_out_if
// Result channel: valid/ready handshake with standardized value and flags.
// ----------------------------------------------------------------------------
interface zsn_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [zsn_pkg::SAMPLE_W-1:0] zvalue;
  logic                                end_of_column;
  logic                                degenerate;
  logic                                overflowed;

  modport source (output valid, output zvalue, output end_of_column,
                  output degenerate, output overflowed, input ready);
  modport sink   (input valid, input zvalue, input end_of_column,
                  input degenerate, input overflowed, output ready);
endinterface

@@ rtl/core/zsn_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsn_ctrl
// Sequencer for loading, column statistics and per-sample scaling.
// ----------------------------------------------------------------------------
module zsn_ctrl #(
  parameter int MAX_SAMPLES = zsn_pkg::MAX_SAMPLES_DEF,
  localparam int ADDR_W = $clog2(MAX_SAMPLES)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_final,
  output logic                in_ready,
  input  zsn_pkg::zsn_status_t status,
  output zsn_pkg::zsn_cmd_t   cmd,
  output logic [ADDR_W-1:0]   addr
);

  typedef enum logic [3:0] {
    S_LOAD, S_PREP1, S_PREP2, S_PREP3, S_RD, S_CALC_A, S_CALC_SQ, S_CALC_NUM,
    S_DIV_INIT, S_DIV, S_SQRT, S_EMIT
  } state_t;

  state_t                      state;
  logic [ADDR_W-1:0]           k;
  logic [zsn_pkg::STEP_W-1:0]  step;
  logic                        accept;

  assign in_ready = (state == S_LOAD);
  assign accept   = in_valid && in_ready;
  assign addr     = k;

  always_comb begin
    cmd           = '0;
    cmd.acc_en    = accept;
    cmd.prep_mul  = (state == S_PREP1);
    cmd.prep_sub  = (state == S_PREP2);
    cmd.prep_nd   = (state == S_PREP3);
    cmd.rd_en     = (state == S_RD);
    cmd.a_en      = (state == S_CALC_A);
    cmd.sq_en     = (state == S_CALC_SQ);
    cmd.num_en    = (state == S_CALC_NUM);
    cmd.div_init  = (state == S_DIV_INIT);
    cmd.div_step  = (state == S_DIV);
    cmd.sqrt_step = (state == S_SQRT);
    cmd.out_load  = (state == S_EMIT) && !status.out_busy;
    cmd.clear     = cmd.out_load && status.last_item;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      k     <= '0;
      step  <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          k <= '0;
          if (accept && in_final) state <= S_PREP1;
        end
        S_PREP1: state <= S_PREP2;
        S_PREP2: state <= S_PREP3;
        S_PREP3: state <= status.degen ? S_EMIT : S_RD;
        S_RD: state <= S_CALC_A;
        S_CALC_A: state <= S_CALC_SQ;
        S_CALC_SQ: state <= S_CALC_NUM;
        S_CALC_NUM: state <= S_DIV_INIT;
        S_DIV_INIT: begin
          step  <= '0;
          state <= S_DIV;
        end
        S_DIV: begin
          // A saturated quotient is already known after the first compare.
          if (status.sat) begin
            state <= S_EMIT;
          end else if (step == zsn_pkg::STEP_W'(zsn_pkg::Q_W - 1)) begin
            step  <= '0;
            state <= S_SQRT;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_SQRT: begin
          if (step == zsn_pkg::STEP_W'(zsn_pkg::ROOT_W - 1)) state <= S_EMIT;
          else step <= step + 1'b1;
        end
        S_EMIT: begin
          if (!status.out_busy) begin
            if (status.last_item) begin
              state <= S_LOAD;
            end else begin
              k     <= k + 1'b1;
              state <= status.degen ? S_EMIT : S_RD;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

@@ rtl/core/zsn_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsn_dp
// Sample store, exact column sums, long divider, square root and output.
// ----------------------------------------------------------------------------
module zsn_dp #(
  parameter int MAX_SAMPLES = zsn_pkg::MAX_SAMPLES_DEF,
  localparam int ADDR_W = $clog2(MAX_SAMPLES),
  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  zsn_pkg::zsn_cmd_t                   cmd,
  input  logic [ADDR_W-1:0]                   addr,
  output zsn_pkg::zsn_status_t                status,
  input  logic signed [zsn_pkg::SAMPLE_W-1:0] sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [zsn_pkg::SAMPLE_W-1:0] zvalue,
  output logic                                end_of_column,
  output logic                                degenerate,
  output logic                                overflowed
);

  localparam int SW = zsn_pkg::SAMPLE_W;
  localparam int QW = zsn_pkg::Q_W;
  localparam int RW = zsn_pkg::ROOT_W;
  localparam int TW = zsn_pkg::RT_W;
  localparam int NW = zsn_pkg::NUM_W;

  logic signed [SW-1:0]            mem [MAX_SAMPLES];
  logic signed [SW-1:0]            rdata;
  logic [CNT_W-1:0]                count;
  logic signed [zsn_pkg::SUM_W-1:0] sum;
  logic [zsn_pkg::SQ_W-1:0]        sq;
  logic                            ovf;
  logic [zsn_pkg::PROD_W-1:0]      nq, ss, d;
  logic [zsn_pkg::ND_W-1:0]        nd;
  logic                            degen, sat, a_neg;
  logic signed [zsn_pkg::A_W-1:0]  a;
  logic [zsn_pkg::MAG_W-1:0]       mag;
  logic [zsn_pkg::A2_W-1:0]        a2;
  logic [NW-1:0]                   num, rem, trem;
  logic [QW-1:0]                   low, q;
  logic [TW-1:0]                   r, rt, trial;
  logic [RW-1:0]                   root;
  logic [zsn_pkg::M_W-1:0]         m;
  logic signed [SW-1:0]            z;
  logic                            room;

  assign room = (count < CNT_W'(MAX_SAMPLES));
  assign mag  = a[zsn_pkg::A_W-1] ? zsn_pkg::MAG_W'(-a) : zsn_pkg::MAG_W'(a);
  assign trem = {rem[NW-2:0], low[QW-1]};
  assign rt   = {r[TW-3:0], q[QW-1:QW-2]};
  assign trial = {1'b0, root, 2'b01};

  // Round half away from zero: the largest odd number not above the root.
  always_comb begin
    m = sat ? zsn_pkg::M_SAT : ((zsn_pkg::M_W'(root) + 1'b1) >> 1);
    if (degen) z = '0;
    else if (a_neg) z = SW'(-m);
    else if (m > zsn_pkg::M_W'(zsn_pkg::Z_MAX)) z = zsn_pkg::Z_MAX;
    else z = SW'(m);
  end

  assign status.degen     = degen;
  assign status.sat       = sat;
  assign status.last_item = (CNT_W'(addr) == count - 1'b1);
  assign status.out_busy  = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.acc_en && room) mem[count[ADDR_W-1:0]] <= sample;
    if (cmd.rd_en) rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      sum   <= '0;
      sq    <= '0;
      ovf   <= 1'b0;
    end else if (cmd.acc_en) begin
      if (room) begin
        count <= count + 1'b1;
        sum   <= sum + zsn_pkg::SUM_W'(sample);
        sq    <= sq + zsn_pkg::SQ_W'(unsigned'((2*SW)'(sample) * (2*SW)'(sample)));
      end else begin
        ovf <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep_mul) begin
      nq <= zsn_pkg::PROD_W'(count) * zsn_pkg::PROD_W'(sq);
      ss <= unsigned'(zsn_pkg::PROD_W'(sum) * zsn_pkg::PROD_W'(sum));
    end
    if (cmd.prep_sub) begin
      d     <= nq - ss;
      degen <= (count < CNT_W'(2)) || (nq == ss);
    end
    if (cmd.prep_nd) nd <= zsn_pkg::ND_W'(count) * zsn_pkg::ND_W'(d);
    if (cmd.a_en) begin
      a     <= zsn_pkg::A_W'($signed({1'b0, count})) * zsn_pkg::A_W'(rdata)
               - zsn_pkg::A_W'(sum);
    end
    if (cmd.sq_en) begin
      a_neg <= a[zsn_pkg::A_W-1];
      a2    <= zsn_pkg::A2_W'(mag) * zsn_pkg::A2_W'(mag);
    end
    if (cmd.num_en) num <= NW'(a2) * NW'(count - 1'b1);
    if (cmd.div_init) begin
      // Numerator is num * 2^26; its upper part seeds the remainder.
      rem  <= num >> (QW - zsn_pkg::FRAC_SHIFT);
      sat  <= (num >> (QW - zsn_pkg::FRAC_SHIFT)) >= NW'(nd);
      low  <= QW'(num << zsn_pkg::FRAC_SHIFT);
      q    <= '0;
      r    <= '0;
      root <= '0;
    end
    if (cmd.div_step) begin
      low <= low << 1;
      if (trem >= NW'(nd)) begin
        rem <= trem - NW'(nd);
        q   <= {q[QW-2:0], 1'b1};
      end else begin
        rem <= trem;
        q   <= {q[QW-2:0], 1'b0};
      end
    end
    if (cmd.sqrt_step) begin
      q <= q << 2;
      if (rt >= trial) begin
        r    <= rt - trial;
        root <= {root[RW-2:0], 1'b1};
      end else begin
        r    <= rt;
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      zvalue        <= z;
      end_of_column <= status.last_item;
      degenerate    <= degen;
      overflowed    <= ovf;
    end
  end

endmodule

@@ rtl/core/zscore_normalizer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zscore_normalizer
// Column z-score standardization, Q4.12 output with sample deviation.
// ----------------------------------------------------------------------------
//  channel   | dir | payload                                          | handshake
//  samples   | in  | sample[15:0] signed, is_final                    | valid/ready
//  results   | out | zvalue[15:0] signed, end_of_column, degenerate,  | valid/ready
//            |     | overflowed                                       |
//
//  Samples load at one per cycle outside emission; a final sample is followed
//  by multiply, subtract and scale statistics steps before the first result.
//  Each result then passes read, three multiply stages, a 32-step long
//  divider and a 16-step square root; degenerate columns give one result
//  per cycle unless the output stalls, and saturated values leave the
//  divider after its first step and skip the root.
//  Reset is synchronous; no clearing pass is needed.
//  Samples are not taken while a column is being emitted; a stalled result
//  holds in the output register, and loading resumes behind the last one.
// ----------------------------------------------------------------------------
module zscore_normalizer #(
  parameter int MAX_SAMPLES = zsn_pkg::MAX_SAMPLES_DEF
) (
  input logic       clk,
  input logic       rst,
  zsn_in_if.sink    samples,
  zsn_out_if.source results
);

  localparam int ADDR_W = $clog2(MAX_SAMPLES);

  zsn_pkg::zsn_cmd_t    cmd;
  zsn_pkg::zsn_status_t status;
  logic [ADDR_W-1:0]    addr;

  zsn_ctrl #(.MAX_SAMPLES(MAX_SAMPLES)) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_final (samples.is_final),
    .in_ready (samples.ready),
    .status   (status),
    .cmd      (cmd),
    .addr     (addr)
  );

  zsn_dp #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .addr          (addr),
    .status        (status),
    .sample        (samples.sample),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .zvalue        (results.zvalue),
    .end_of_column (results.end_of_column),
    .degenerate    (results.degenerate),
    .overflowed    (results.overflowed)
  );

endmodule

@@ rtl/core/zsn_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zsn_checker
// Port-level checks on sequencing and result flags of the normalizer.
// ----------------------------------------------------------------------------
module zsn_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                in_final,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [zsn_pkg::SAMPLE_W-1:0] zvalue,
  input logic                                end_of_column,
  input logic                                degenerate
);

  // A final sample starts emission, so loading pauses right after it.
  a_final_stops_load: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_final |=> !in_ready)
    else $error("samples still accepted after a final sample");

  // While loading, only the last result of a column can still be waiting.
  a_wait_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && in_ready |-> end_of_column)
    else $error("non-final result pending while loading");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> zvalue == '0)
    else $error("degenerate result with nonzero value");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(zvalue))
    else $error("stalled result changed");

endmodule

bind zscore_normalizer zsn_checker u_zsn_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (samples.valid),
  .in_ready      (samples.ready),
  .in_final      (samples.is_final),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .zvalue        (results.zvalue),
  .end_of_column (results.end_of_column),
  .degenerate    (results.degenerate)
);

@@ tb/sv/zscore_normalizer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// zscore_normalizer_tb
// Drives columns of samples through the normalizer and checks every result
// against an exact integer model of the z-score and its flags. A short table
// covers the extremes and degenerate columns, then random columns follow,
// some long enough to overflow the store, under three idling patterns.
// ----------------------------------------------------------------------------
module zscore_normalizer_tb;

  localparam int CAPACITY = zsn_pkg::MAX_SAMPLES_DEF;
  localparam int SW       = zsn_pkg::SAMPLE_W;

  typedef struct {
    logic signed [SW-1:0] zvalue;
    logic                 end_of_column;
    logic                 degenerate;
    logic                 overflowed;
  } zresult_t;

  typedef struct {
    logic signed [SW-1:0] sample;
    logic                 is_final;
    logic                 flat;  // typed expectation: zero values, degenerate
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  zsn_in_if  smp ();
  zsn_out_if res ();

  zscore_normalizer u_dut (
    .clk     (clk),
    .rst     (rst),
    .samples (smp),
    .results (res)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  zresult_t             pending_z[$];
  logic signed [SW-1:0] column[$];
  logic                 column_dropped = 1'b0;
  int                   errors = 0;
  int                   send_idle_pct = 0;
  int                   recv_idle_pct = 0;

  stim_row_t directed[] = '{
    '{-16'sd32768, 1'b1, 1'b1},                         // single sample
    '{16'sd32767, 1'b0, 1'b0}, '{16'sd32767, 1'b0, 1'b0},
    '{16'sd32767, 1'b1, 1'b1},                          // zero variance
    '{-16'sd32768, 1'b0, 1'b0}, '{16'sd32767, 1'b1, 1'b0},
    '{16'sd0, 1'b0, 1'b0}, '{16'sd1, 1'b1, 1'b0},
    '{-16'sd1, 1'b0, 1'b0}, '{-16'sd32768, 1'b0, 1'b0},
    '{-16'sd32768, 1'b0, 1'b0}, '{-16'sd32768, 1'b0, 1'b0},
    '{16'sd32767, 1'b1, 1'b0},                          // outlier against a cluster
    '{16'sd0, 1'b0, 1'b0}, '{16'sd0, 1'b1, 1'b1},
    '{16'sh5555, 1'b0, 1'b0}, '{-16'sh2aab, 1'b0, 1'b0},
    '{16'sd100, 1'b0, 1'b0}, '{16'sd101, 1'b1, 1'b0}
  };

  // Rounded, saturated Q4.12 of a * sqrt((n-1)/nd), searched exactly.
  function automatic logic signed [SW-1:0] q412_scale(longint a, longint n, longint nd);
    bit [127:0] limit;
    bit [127:0] lhs;
    longint     mag;
    longint     lo;
    longint     hi;
    longint     mid;
    mag   = (a < 0) ? -a : a;
    limit = (128'(mag) * 128'(mag) * 128'(n - 1)) << zsn_pkg::FRAC_SHIFT;
    lo    = 0;
    hi    = 32768;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      lhs = 128'(2 * mid - 1) * 128'(2 * mid - 1) * 128'(nd);
      if (lhs <= limit) lo = mid;
      else hi = mid - 1;
    end
    if (a < 0) return SW'(-lo);
    return (lo > 32767) ? 16'sh7fff : SW'(lo);
  endfunction

  // Standardizes the finished column into the queue of pending results.
  task automatic standardize_column(input logic flat);
    longint   n;
    longint   s;
    longint   q;
    longint   d;
    logic     degen;
    zresult_t r;
    n = column.size();
    s = 0;
    q = 0;
    foreach (column[i]) begin
      s += column[i];
      q += longint'(column[i]) * column[i];
    end
    d = n * q - s * s;
    degen = (n < 2) || (d <= 0);
    foreach (column[i]) begin
      r.zvalue        = degen ? '0 : q412_scale(n * column[i] - s, n, n * d);
      r.end_of_column = (i == n - 1);
      r.degenerate    = degen;
      r.overflowed    = column_dropped;
      if (flat) begin
        r.zvalue     = '0;
        r.degenerate = 1'b1;
      end
      pending_z.push_back(r);
    end
    column.delete();
    column_dropped = 1'b0;
  endtask

  task automatic take_sample(input logic signed [SW-1:0] x, input logic fin,
                             input logic flat);
    if (column.size() < CAPACITY) column.push_back(x);
    else column_dropped = 1'b1;
    if (fin) standardize_column(flat);
  endtask

  task automatic send_sample(input logic signed [SW-1:0] x, input logic fin,
                             input logic flat);
    while ($urandom_range(99) < send_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid    <= 1'b1;
    smp.sample   <= x;
    smp.is_final <= fin;
    do @(posedge clk); while (!smp.ready);
    take_sample(x, fin, flat);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    zresult_t want;
    if (rst) begin
      res.ready <= 1'b0;
    end else begin
      if (res.valid && res.ready) begin
        if (pending_z.size() == 0) begin
          report_mismatch("result count", 1, 0);
        end else begin
          want = pending_z.pop_front();
          if (res.zvalue !== want.zvalue)
            report_mismatch("zvalue", res.zvalue, want.zvalue);
          if (res.end_of_column !== want.end_of_column)
            report_mismatch("end_of_column", res.end_of_column, want.end_of_column);
          if (res.degenerate !== want.degenerate)
            report_mismatch("degenerate", res.degenerate, want.degenerate);
          if (res.overflowed !== want.overflowed)
            report_mismatch("overflowed", res.overflowed, want.overflowed);
        end
      end
      res.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One random column; mode picks full range, clustered, constant or extreme values.
  task automatic send_random_column(input int len);
    int                   mode;
    logic signed [SW-1:0] base;
    logic signed [SW-1:0] x;
    mode = $urandom_range(9);
    base = SW'($urandom);
    for (int i = 0; i < len; i++) begin
      if (mode < 5) x = SW'($urandom);
      else if (mode < 7) x = base + SW'($urandom_range(16)) - SW'(8);
      else if (mode < 8) x = base;
      else x = $urandom_range(1) ? 16'sh7fff : -16'sh8000;
      send_sample(x, i == len - 1, 1'b0);
    end
  endtask

  initial begin
    smp.valid    = 1'b0;
    smp.sample   = '0;
    smp.is_final = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 80 : 0;
      recv_idle_pct = (phase == 0) ? 80 : (phase == 1) ? 14 : 0;
      if (phase == 0)
        foreach (directed[i])
          send_sample(directed[i].sample, directed[i].is_final, directed[i].flat);
      // One column runs past the store so the drop path is exercised.
      send_random_column($urandom_range(CAPACITY + 1, CAPACITY + 6));
      for (int sent = 0; sent < 60; ) begin
        automatic int len = $urandom_range(1, 10);
        send_random_column(len);
        sent += len;
      end
      smp.valid <= 1'b0;
      while (pending_z.size() != 0) @(posedge clk);
    end
    repeat (100) @(posedge clk);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #8ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/core/zsn_pkg.sv
rtl/core/zsn_in_if.sv
rtl/core/zsn_out_if.sv
rtl/core/zsn_ctrl.sv
rtl/core/zsn_dp.sv
rtl/core/zscore_normalizer.sv
rtl/core/zsn_checker.sv
tb/sv/zscore_normalizer_tb.sv
